@@ hw/rtl/crtvtc_pkg.sv @@
// Package for the CRT video timing controller.
// Holds the command codes, register constants, write masks and the result record.
// No dependencies; used by crtvtc_engine and the top level.
package crtvtc_pkg;

    // Command carried in the input tuser field.
    typedef enum logic [1:0] {
        CMD_SELECT = 2'd0,
        CMD_WRITE  = 2'd1,
        CMD_READ   = 2'd2,
        CMD_TICK   = 2'd3
    } cmd_t;

    localparam int unsigned NUM_REGS = 18;
    localparam logic [4:0] LAST_REG       = 5'd17;
    localparam logic [4:0] FIRST_READABLE = 5'd14;
    localparam logic [4:0] MAX_SELECT     = 5'd31;
    localparam logic [7:0] ADDR_HIGH_MASK = 8'h3F;

    // Register indexes used by the timing logic.
    localparam int unsigned REG_H_TOTAL     = 0;
    localparam int unsigned REG_H_DISPLAYED = 1;
    localparam int unsigned REG_V_TOTAL     = 4;
    localparam int unsigned REG_V_ADJUST    = 5;
    localparam int unsigned REG_V_DISPLAYED = 6;
    localparam int unsigned REG_MAX_RASTER  = 9;
    localparam int unsigned REG_START_HI    = 12;
    localparam int unsigned REG_START_LO    = 13;
    localparam int unsigned REG_CURSOR_HI   = 14;
    localparam int unsigned REG_CURSOR_LO   = 15;
    localparam int unsigned REG_LIGHT_PEN_HI = 16;

    // Bits that each register keeps on a write.
    localparam logic [7:0] WRITE_MASK [NUM_REGS] = '{
        8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7F, 8'h1F, 8'h7F, 8'h7F, 8'hF3,
        8'h1F, 8'h7F, 8'h1F, 8'h3F, 8'hFF, 8'h3F, 8'hFF, 8'h3F, 8'hFF
    };

    // Output tdata layout.
    localparam int unsigned M_TDATA_WIDTH = 80;

    // One result item, values after the command has taken effect.
    typedef struct packed {
        logic [7:0]  read_data;
        logic        display_enable;
        logic [13:0] display_start;
        logic [13:0] cursor_address;
        logic [7:0]  char_column;
        logic [4:0]  scan_row;
        logic [6:0]  text_row;
        logic        adjust_active;
        logic        frame_done;
        logic [15:0] frame_count;
    } result_t;

endpackage

@@ hw/rtl/crtvtc_engine.sv @@
// Register file and character, raster and row counters of the timing controller.
// Applies one command per step and gives the resulting values combinationally.
// Depends on crtvtc_pkg.
module crtvtc_engine (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 step,
    input  crtvtc_pkg::cmd_t     cmd,
    input  logic [7:0]           value,
    output crtvtc_pkg::result_t  result
);

    logic [7:0]  reg_file_reg  [crtvtc_pkg::NUM_REGS];
    logic [7:0]  reg_file_next [crtvtc_pkg::NUM_REGS];
    logic [4:0]  sel_reg, sel_next;
    logic [7:0]  col_reg, col_next;
    logic [4:0]  raster_reg, raster_next;
    logic [6:0]  row_reg, row_next;
    logic [5:0]  adj_cnt_reg, adj_cnt_next;
    logic        in_adj_reg, in_adj_next;
    logic [15:0] frames_reg, frames_next;
    logic [5:0]  adj_inc;
    logic [7:0]  rd_data;
    logic        done;

    // Next state for the command in hand.
    always_comb begin
        reg_file_next = reg_file_reg;
        sel_next      = sel_reg;
        col_next      = col_reg;
        raster_next   = raster_reg;
        row_next      = row_reg;
        adj_cnt_next  = adj_cnt_reg;
        in_adj_next   = in_adj_reg;
        frames_next   = frames_reg;
        rd_data       = 8'd0;
        done          = 1'b0;
        adj_inc       = adj_cnt_reg + 6'd1;
        case (cmd)
            crtvtc_pkg::CMD_SELECT: begin
                sel_next = (|value[7:5]) ? crtvtc_pkg::MAX_SELECT : value[4:0];
            end
            crtvtc_pkg::CMD_WRITE: begin
                if (sel_reg <= crtvtc_pkg::LAST_REG) begin
                    reg_file_next[sel_reg] = value & crtvtc_pkg::WRITE_MASK[sel_reg];
                end
            end
            crtvtc_pkg::CMD_READ: begin
                if (sel_reg >= crtvtc_pkg::FIRST_READABLE
                        && sel_reg <= crtvtc_pkg::LAST_REG) begin
                    rd_data = reg_file_reg[sel_reg];
                end
            end
            crtvtc_pkg::CMD_TICK: begin
                if (col_reg >= reg_file_reg[crtvtc_pkg::REG_H_TOTAL]) begin
                    // End of the scan line.
                    col_next = 8'd0;
                    if (in_adj_reg) begin
                        adj_cnt_next = adj_inc;
                        if ({2'b00, adj_inc} > reg_file_reg[crtvtc_pkg::REG_V_ADJUST]) begin
                            in_adj_next  = 1'b0;
                            adj_cnt_next = 6'd0;
                            row_next     = 7'd0;
                            raster_next  = 5'd0;
                            frames_next  = frames_reg + 16'd1;
                            done         = 1'b1;
                        end
                    end else if ({3'b000, raster_reg}
                            < reg_file_reg[crtvtc_pkg::REG_MAX_RASTER]) begin
                        raster_next = raster_reg + 5'd1;
                    end else begin
                        raster_next = 5'd0;
                        if ({1'b0, row_reg} < reg_file_reg[crtvtc_pkg::REG_V_TOTAL]) begin
                            row_next = row_reg + 7'd1;
                        end else if (reg_file_reg[crtvtc_pkg::REG_V_ADJUST] != 8'd0) begin
                            in_adj_next  = 1'b1;
                            adj_cnt_next = 6'd0;
                        end else begin
                            row_next    = 7'd0;
                            frames_next = frames_reg + 16'd1;
                            done        = 1'b1;
                        end
                    end
                end else begin
                    col_next = col_reg + 8'd1;
                end
            end
            default: begin
                sel_next = sel_reg;
            end
        endcase
    end

    // Result values seen after the command.
    always_comb begin
        result.read_data      = rd_data;
        result.display_enable =
            (col_next < reg_file_next[crtvtc_pkg::REG_H_DISPLAYED])
            && ({1'b0, row_next} < reg_file_next[crtvtc_pkg::REG_V_DISPLAYED])
            && !in_adj_next;
        result.display_start  =
            {reg_file_next[crtvtc_pkg::REG_START_HI][5:0],
             reg_file_next[crtvtc_pkg::REG_START_LO]};
        result.cursor_address =
            {reg_file_next[crtvtc_pkg::REG_CURSOR_HI][5:0],
             reg_file_next[crtvtc_pkg::REG_CURSOR_LO]};
        result.char_column    = col_next;
        result.scan_row       = raster_next;
        result.text_row       = row_next;
        result.adjust_active  = in_adj_next;
        result.frame_done     = done;
        result.frame_count    = frames_next;
    end

    // State registers advance once per step.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < crtvtc_pkg::NUM_REGS; i++) begin
                reg_file_reg[i] <= 8'd0;
            end
            sel_reg     <= 5'd0;
            col_reg     <= 8'd0;
            raster_reg  <= 5'd0;
            row_reg     <= 7'd0;
            adj_cnt_reg <= 6'd0;
            in_adj_reg  <= 1'b0;
            frames_reg  <= 16'd0;
        end else if (step) begin
            reg_file_reg <= reg_file_next;
            sel_reg      <= sel_next;
            col_reg      <= col_next;
            raster_reg   <= raster_next;
            row_reg      <= row_next;
            adj_cnt_reg  <= adj_cnt_next;
            in_adj_reg   <= in_adj_next;
            frames_reg   <= frames_next;
        end
    end

endmodule

@@ hw/rtl/crt_video_timing_controller_top.sv @@
// Top level of the CRT video timing controller: stream ports, input and result registers.
// Instantiates crtvtc_engine; depends on crtvtc_pkg.
//
//  Channel  | Direction | tdata                    | tuser    | tlast
//  s_       | in        | value                    | command  | -
//  m_       | out       | result fields, 80 bits   | -        | frame_done
//
// The engine applies each command in one step; one transfer per cycle is sustained while
// m_tready is high. From input transfer to result an item passes the input register, then
// the engine logic into the result register. The input register lets one transfer in while
// a result waits. Reset is synchronous and active low; it clears the valid flags and the
// engine state, not the payloads. A stalled result holds the input register, then s_tready falls.
module crt_video_timing_controller_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] value
    input  logic [1:0]  s_tuser,   // [1:0] command
    output logic        m_tvalid,
    input  logic        m_tready,
    // [7:0] read_data, [8] display_enable, [22:9] display_start,
    // [36:23] cursor_address, [44:37] char_column, [49:45] scan_row,
    // [56:50] text_row, [57] adjust_active, [73:58] frame_count, [79:74] zero
    output logic [79:0] m_tdata,
    output logic        m_tlast    // frame_done
);

    logic               in_valid_reg, in_valid_next;
    crtvtc_pkg::cmd_t   in_cmd_reg;
    logic [7:0]         in_value_reg;
    logic               out_valid_reg, out_valid_next;
    logic [79:0]        out_data_reg;
    logic               out_last_reg;
    logic               advance;
    logic               s_xfer;
    crtvtc_pkg::result_t result;

    // Handshake: the held item moves on when the result register is free or emptying.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign s_xfer   = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_xfer) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end
        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // Valid flags.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Input register payload.
    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            in_cmd_reg   <= crtvtc_pkg::cmd_t'(s_tuser);
            in_value_reg <= s_tdata;
        end
    end

    crtvtc_engine u_engine (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .cmd     (in_cmd_reg),
        .value   (in_value_reg),
        .result  (result)
    );

    // Result register payload, packed lowest field first.
    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= {6'd0, result.frame_count, result.adjust_active,
                             result.text_row, result.scan_row, result.char_column,
                             result.cursor_address, result.display_start,
                             result.display_enable, result.read_data};
            out_last_reg <= result.frame_done;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

`ifndef NO_ASSERTIONS
    // A frame end always leaves the row and raster counters at zero, outside adjust.
    a_frame_end_counters: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tlast) |-> (m_tdata[56:45] == 12'd0 && !m_tdata[57]))
        else $error("frame end with counters not cleared");

    // Display is never enabled during the vertical adjust lines.
    a_no_display_in_adjust: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[57]) |-> !m_tdata[8])
        else $error("display enabled during adjust");

    // An item leaving the input register always appears as a result next cycle.
    a_advance_gives_result: assert property (@(posedge aclk) disable iff (!aresetn)
        advance |=> m_tvalid)
        else $error("advanced item produced no result");

    // For an item without a frame end, the result register takes the engine's frame count.
    a_frame_count_step: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && !result.frame_done) |=> (out_data_reg[73:58] == $past(result.frame_count)))
        else $error("frame count changed without frame end");
`endif

endmodule

@@ bench/tb_crt_video_timing_controller_top.sv @@
// Self-checking testbench for crt_video_timing_controller_top: drives register and tick
// commands, predicts every status transfer and compares it field by field.
// Depends on crtvtc_pkg and the top level of the block only.
`timescale 1ns / 100ps

module tb_crt_video_timing_controller_top;

    localparam int unsigned ITEM_TARGET = 1400;
    localparam int unsigned MAX_REPORTS = 10;
    localparam int unsigned DRAIN_CYCLES = 8;

    // Timing model of the controller and store of the status transfers still due.
    class timing_scoreboard;
        logic [7:0]  regs [crtvtc_pkg::NUM_REGS];
        logic [4:0]  sel;
        logic [7:0]  col;
        logic [4:0]  raster;
        logic [6:0]  row;
        logic [5:0]  adj_cnt;
        logic        in_adj;
        logic [15:0] frames;
        crtvtc_pkg::result_t status_due [$];
        int unsigned errors;
        int unsigned checked;

        function new();
            foreach (regs[i]) regs[i] = '0;
            sel = '0;
            col = '0;
            raster = '0;
            row = '0;
            adj_cnt = '0;
            in_adj = 1'b0;
            frames = '0;
            errors = 0;
            checked = 0;
        endfunction

        // Applies one accepted command and queues the status it must produce.
        function void note_command(crtvtc_pkg::cmd_t c, logic [7:0] v);
            crtvtc_pkg::result_t r;
            logic    frame_wrap;
            r = '0;
            frame_wrap = 1'b0;
            case (c)
                crtvtc_pkg::CMD_SELECT: begin
                    sel = (v > crtvtc_pkg::MAX_SELECT) ? crtvtc_pkg::MAX_SELECT : v[4:0];
                end
                crtvtc_pkg::CMD_WRITE: begin
                    if (sel <= crtvtc_pkg::LAST_REG) regs[sel] = v & crtvtc_pkg::WRITE_MASK[sel];
                end
                crtvtc_pkg::CMD_READ: begin
                    if (sel >= crtvtc_pkg::FIRST_READABLE && sel <= crtvtc_pkg::LAST_REG)
                        r.read_data = regs[sel];
                end
                default: begin
                    if (col >= regs[crtvtc_pkg::REG_H_TOTAL]) begin
                        // End of a scan line: adjust lines first, then raster, then row.
                        col = '0;
                        if (in_adj) begin
                            adj_cnt = adj_cnt + 6'd1;
                            if (adj_cnt > regs[crtvtc_pkg::REG_V_ADJUST]) begin
                                in_adj = 1'b0;
                                adj_cnt = '0;
                                frame_wrap = 1'b1;
                            end
                        end else if (raster < regs[crtvtc_pkg::REG_MAX_RASTER]) begin
                            raster = raster + 5'd1;
                        end else begin
                            raster = '0;
                            if (row < regs[crtvtc_pkg::REG_V_TOTAL]) begin
                                row = row + 7'd1;
                            end else if (regs[crtvtc_pkg::REG_V_ADJUST] != 8'd0) begin
                                in_adj = 1'b1;
                                adj_cnt = '0;
                            end else begin
                                frame_wrap = 1'b1;
                            end
                        end
                    end else begin
                        col = col + 8'd1;
                    end
                end
            endcase
            if (frame_wrap) begin
                row = '0;
                raster = '0;
                frames = frames + 16'd1;
            end
            r.display_enable = (col < regs[crtvtc_pkg::REG_H_DISPLAYED])
                               && (row < regs[crtvtc_pkg::REG_V_DISPLAYED]) && !in_adj;
            r.display_start  = {regs[crtvtc_pkg::REG_START_HI][5:0],
                                regs[crtvtc_pkg::REG_START_LO]};
            r.cursor_address = {regs[crtvtc_pkg::REG_CURSOR_HI][5:0],
                                regs[crtvtc_pkg::REG_CURSOR_LO]};
            r.char_column    = col;
            r.scan_row       = raster;
            r.text_row       = row;
            r.adjust_active  = in_adj;
            r.frame_done     = frame_wrap;
            r.frame_count    = frames;
            status_due.push_back(r);
        endfunction

        function int unsigned pending();
            return status_due.size();
        endfunction

        function bit field_differs(string name, logic [15:0] e, logic [15:0] a);
            if (e !== a) begin
                if (errors < MAX_REPORTS)
                    $display("status %0d, %s: expected %h, got %h", checked, name, e, a);
                return 1'b1;
            end
            return 1'b0;
        endfunction

        // Compares one accepted status transfer with the oldest one due.
        function void check_result(logic [79:0] data, logic last);
            crtvtc_pkg::result_t want;
            bit      differs;
            if (status_due.size() == 0) begin
                if (errors < MAX_REPORTS)
                    $display("status %0d arrived with none due: %h", checked, data);
                errors++;
                checked++;
                return;
            end
            want = status_due.pop_front();
            differs = 1'b0;
            differs |= field_differs("read_data", want.read_data, data[7:0]);
            differs |= field_differs("display_enable", want.display_enable, data[8]);
            differs |= field_differs("display_start", want.display_start, data[22:9]);
            differs |= field_differs("cursor_address", want.cursor_address, data[36:23]);
            differs |= field_differs("char_column", want.char_column, data[44:37]);
            differs |= field_differs("scan_row", want.scan_row, data[49:45]);
            differs |= field_differs("text_row", want.text_row, data[56:50]);
            differs |= field_differs("adjust_active", want.adjust_active, data[57]);
            differs |= field_differs("frame_count", want.frame_count, data[73:58]);
            differs |= field_differs("padding", 16'd0, data[79:74]);
            differs |= field_differs("frame_done", want.frame_done, last);
            if (differs) errors++;
            checked++;
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [79:0] m_tdata;
    logic        m_tlast;

    timing_scoreboard board = new();
    int unsigned      items_sent = 0;

    crt_video_timing_controller_top dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Offers one command from a falling edge and waits for its transfer.
    task automatic send_item(crtvtc_pkg::cmd_t c, logic [7:0] v);
        @(negedge aclk);
        // The sender runs without gaps for a stretch of items in the middle of the run.
        if (items_sent < 400 || items_sent >= 650) begin
            while ($urandom_range(0, 99) < 37) begin
                s_tvalid = 1'b0;
                @(negedge aclk);
            end
        end
        s_tvalid = 1'b1;
        s_tuser = c;
        s_tdata = v;
        do @(posedge aclk); while (!s_tready);
        board.note_command(c, v);
        items_sent++;
    endtask

    task automatic program_reg(int unsigned idx, logic [7:0] v);
        send_item(crtvtc_pkg::CMD_SELECT, idx[7:0]);
        send_item(crtvtc_pkg::CMD_WRITE, v);
    endtask

    // Stimulus: directed register and tick cases, then random timing set-ups.
    initial begin : stimulus
        int unsigned profile;
        int unsigned burst;
        int unsigned pick;
        logic [7:0]  h_last;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = crtvtc_pkg::CMD_SELECT;
        aresetn = 1'b0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // With every register at zero each tick completes a frame.
        send_item(crtvtc_pkg::CMD_READ, 8'h00);
        send_item(crtvtc_pkg::CMD_TICK, 8'hFF);
        send_item(crtvtc_pkg::CMD_TICK, 8'h00);
        // Selection saturates; writes beyond the last register are dropped.
        send_item(crtvtc_pkg::CMD_SELECT, 8'hFF);
        send_item(crtvtc_pkg::CMD_WRITE, 8'hAA);
        send_item(crtvtc_pkg::CMD_READ, 8'h00);
        send_item(crtvtc_pkg::CMD_SELECT, {3'b000, crtvtc_pkg::LAST_REG} + 8'd1);
        send_item(crtvtc_pkg::CMD_WRITE, 8'h55);
        send_item(crtvtc_pkg::CMD_READ, 8'h00);
        // Readable registers with their write masks applied.
        program_reg(crtvtc_pkg::REG_CURSOR_HI, 8'hFF);
        send_item(crtvtc_pkg::CMD_READ, 8'h00);
        program_reg(crtvtc_pkg::REG_CURSOR_LO, 8'hFF);
        send_item(crtvtc_pkg::CMD_READ, 8'h00);
        program_reg(crtvtc_pkg::REG_LIGHT_PEN_HI, 8'hFF);
        send_item(crtvtc_pkg::CMD_READ, 8'h00);
        program_reg(crtvtc_pkg::LAST_REG, 8'h00);
        send_item(crtvtc_pkg::CMD_READ, 8'h00);
        // Start address, then a read of a register that does not read back.
        program_reg(crtvtc_pkg::REG_START_HI, 8'hFF);
        program_reg(crtvtc_pkg::REG_START_LO, 8'h80);
        send_item(crtvtc_pkg::CMD_READ, 8'h00);

        // Random phases, each with its own register set-up and a burst of commands.
        while (items_sent < ITEM_TARGET) begin
            profile = $urandom_range(0, 11);
            if (profile < 7) begin
                // Small frames so that lines, rows, adjust and frames all turn over.
                h_last = 8'($urandom_range(0, 6));
                program_reg(crtvtc_pkg::REG_H_TOTAL, h_last);
                program_reg(crtvtc_pkg::REG_H_DISPLAYED, 8'($urandom_range(0, h_last + 1)));
                program_reg(crtvtc_pkg::REG_MAX_RASTER, 8'($urandom_range(0, 3)));
                program_reg(crtvtc_pkg::REG_V_TOTAL, 8'($urandom_range(0, 3)));
                program_reg(crtvtc_pkg::REG_V_ADJUST, 8'($urandom_range(0, 3)));
                program_reg(crtvtc_pkg::REG_V_DISPLAYED, 8'($urandom_range(0, 4)));
                program_reg(crtvtc_pkg::REG_START_HI + $urandom_range(0, 3),
                            8'($urandom_range(0, 255)));
            end else if (profile < 9) begin
                for (int i = 0; i < crtvtc_pkg::NUM_REGS; i++)
                    program_reg(i, 8'($urandom_range(0, 255)));
            end else if (profile == 9) begin
                for (int i = 0; i < crtvtc_pkg::NUM_REGS; i++) program_reg(i, 8'hFF);
            end else if (profile == 10) begin
                for (int i = 0; i < crtvtc_pkg::NUM_REGS; i++) program_reg(i, 8'h00);
            end else begin
                // One tick per line and the longest vertical adjust.
                program_reg(crtvtc_pkg::REG_H_TOTAL, 8'h00);
                program_reg(crtvtc_pkg::REG_MAX_RASTER, 8'h00);
                program_reg(crtvtc_pkg::REG_V_TOTAL, 8'h00);
                program_reg(crtvtc_pkg::REG_V_ADJUST, 8'hFF);
                program_reg(crtvtc_pkg::REG_H_DISPLAYED, 8'hFF);
                program_reg(crtvtc_pkg::REG_V_DISPLAYED, 8'hFF);
            end
            burst = $urandom_range(40, 120);
            repeat (burst) begin
                pick = $urandom_range(0, 99);
                if (pick < 75)
                    send_item(crtvtc_pkg::CMD_TICK, 8'($urandom_range(0, 255)));
                else if (pick < 83)
                    send_item(crtvtc_pkg::CMD_SELECT,
                              pick[0] ? 8'($urandom_range(0, 255))
                                      : 8'($urandom_range(0, crtvtc_pkg::LAST_REG)));
                else if (pick < 91)
                    send_item(crtvtc_pkg::CMD_WRITE, 8'($urandom_range(0, 255)));
                else
                    send_item(crtvtc_pkg::CMD_READ, 8'($urandom_range(0, 255)));
            end
        end
        @(negedge aclk);
        s_tvalid = 1'b0;

        // Drain, then wait DRAIN_CYCLES more for any stray transfer.
        while (board.pending() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (board.errors == 0 && board.pending() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Receiver readiness, with one long hold-off and one stretch without gaps.
    initial begin : sink
        int unsigned cycle;
        m_tready = 1'b0;
        cycle = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            cycle++;
            if (cycle >= 700 && cycle < 790)
                m_tready = 1'b0;
            else if (cycle >= 1800 && cycle < 2400)
                m_tready = 1'b1;
            else
                m_tready = ($urandom_range(0, 99) >= 37);
        end
    end

    // Every accepted status transfer is checked at the rising edge.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) board.check_result(m_tdata, m_tlast);
    end

    // Guard against a hung handshake.
    initial begin : watchdog
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ crt_video_timing_controller_top.f @@
hw/rtl/crtvtc_pkg.sv
hw/rtl/crtvtc_engine.sv
hw/rtl/crt_video_timing_controller_top.sv
bench/tb_crt_video_timing_controller_top.sv
